// ----- design/chgs_pkg.sv -----
// Shared types and constants for the convex hull block.
package chgs_pkg;

    localparam int MAX_POINTS = 64;
    localparam int COORD_W    = 16;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TOO_FEW  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } point_t;

    // request passed from front to back
    typedef struct packed {
        point_t             pt;
        logic               store;
        logic [ADDR_W-1:0]  addr;
        logic               last;
        logic [CNT_W-1:0]   n;
        logic               ovf;
    } req_t;

    typedef struct packed {
        point_t      pt;
        logic        last;
        logic [1:0]  status;
    } res_t;

endpackage

// ----- design/chgs_fifo.sv -----
// Short request queue between front and back.
module chgs_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  chgs_pkg::req_t wdata,
    output logic           full,
    input  logic           rd,
    output logic           valid,
    output chgs_pkg::req_t rdata
);
    import chgs_pkg::*;

    req_t               mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wp_reg, wp_next;
    logic [QPTR_W-1:0]  rp_reg, rp_next;
    logic [QPTR_W:0]    cnt_reg, cnt_next;
    logic               do_wr, do_rd;

    assign full  = (cnt_reg == (QPTR_W+1)'(QDEPTH));
    assign valid = (cnt_reg != '0);
    assign rdata = mem_reg[rp_reg];
    assign do_wr = wr && !full;
    assign do_rd = rd && valid;

    always_comb
    begin
        wp_next  = do_wr ? wp_reg + 1'b1 : wp_reg;
        rp_next  = do_rd ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + (QPTR_W+1)'(do_wr) - (QPTR_W+1)'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

endmodule

// ----- design/chgs_front.sv -----
// Front end: accepts points, assigns store slots, flags drops and set ends.
module chgs_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic signed [chgs_pkg::COORD_W-1:0] point_x,
    input  logic signed [chgs_pkg::COORD_W-1:0] point_y,
    input  logic                         last,
    input  logic                         q_full,
    output logic                         q_push,
    output chgs_pkg::req_t               q_data
);
    import chgs_pkg::*;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;
    logic             room;

    assign room   = (cnt_reg < CNT_W'(MAX_POINTS));
    assign q_push = push && !q_full;

    always_comb
    begin
        q_data.pt.x  = point_x;
        q_data.pt.y  = point_y;
        q_data.store = room;
        q_data.addr  = cnt_reg[ADDR_W-1:0];
        q_data.last  = last;
        q_data.n     = room ? cnt_reg + 1'b1 : cnt_reg;
        q_data.ovf   = ovf_reg || !room;
        cnt_next     = cnt_reg;
        ovf_next     = ovf_reg;
        if (q_push)
        begin
            if (last)
            begin
                cnt_next = '0;
                ovf_next = 1'b0;
            end
            else
            begin
                cnt_next = q_data.n;
                ovf_next = q_data.ovf;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
        end
    end

endmodule

// ----- design/chgs_back.sv -----
// Back end: stores points, finds pivot, sorts by angle, scans and emits hull or status.
module chgs_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  chgs_pkg::req_t q_data,
    output logic           q_pop,
    output logic           res_valid,
    output chgs_pkg::res_t res_data,
    input  logic           res_ready
);
    import chgs_pkg::*;

    typedef enum logic [22:0] {
        S_IDLE     = 23'h000001,
        S_STAT     = 23'h000002,
        S_PV_RD    = 23'h000004,
        S_PV_CMP   = 23'h000008,
        S_SW_RD    = 23'h000010,
        S_SW_WR    = 23'h000020,
        S_SW_W0    = 23'h000040,
        S_SR_KEY   = 23'h000080,
        S_SR_KEYD  = 23'h000100,
        S_SR_CHK   = 23'h000200,
        S_SR_M1    = 23'h000400,
        S_SR_M2    = 23'h000800,
        S_SR_DEC   = 23'h001000,
        S_SC_INIT  = 23'h002000,
        S_SC_INITD = 23'h004000,
        S_SC_NEXT  = 23'h008000,
        S_SC_CUR   = 23'h010000,
        S_SC_CHK   = 23'h020000,
        S_SC_M1    = 23'h040000,
        S_SC_M2    = 23'h080000,
        S_SC_DEC   = 23'h100000,
        S_OUT_RD   = 23'h200000,
        S_OUT      = 23'h400000
    } state_t;

    state_t state_reg, state_next;

    point_t pts_mem [MAX_POINTS];
    point_t stk_mem [MAX_POINTS];
    point_t pts_rdata_reg, stk_rdata_reg;

    logic               pts_re, pts_we, stk_re, stk_we;
    logic [ADDR_W-1:0]  pts_raddr, pts_waddr, stk_raddr, stk_waddr;
    point_t             pts_wdata, stk_wdata;

    logic [CNT_W-1:0]   n_reg, n_next, i_reg, i_next, d_reg, d_next;
    logic [ADDR_W-1:0]  j_reg, j_next, piv_reg, piv_next;
    logic [1:0]         st_reg, st_next;
    point_t             pv_reg, pv_next, key_reg, key_next;
    point_t             top_reg, top_next, cur_reg, cur_next;
    logic signed [PROD_W-1:0] p1_reg, p1_next, p2_reg, p2_next;

    logic signed [DIFF_W-1:0] ma, mb;
    logic signed [PROD_W-1:0] prod;
    logic signed [DIFF_W-1:0] ax, ay, bx, by, ay_a, by_a;
    logic signed [DIFF_W-1:0] qpx, qpy, rqx, rqy;
    logic [1:0]               ca, cb;
    logic                     goes_first;

    function automatic logic signed [DIFF_W-1:0] dif(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        return DIFF_W'(a) - DIFF_W'(b);
    endfunction

    function automatic logic [1:0] aclass(
        input logic signed [DIFF_W-1:0] dx,
        input logic signed [DIFF_W-1:0] dy
    );
        logic [1:0] c;
        c = 2'd1;
        if (dy == '0 && dx > 0)
            c = 2'd0;
        else if (dy == '0 && dx < 0)
            c = 2'd2;
        return c;
    endfunction

    always_comb
    begin
        ax   = dif(key_reg.x, pv_reg.x);
        ay   = dif(key_reg.y, pv_reg.y);
        bx   = dif(pts_rdata_reg.x, pv_reg.x);
        by   = dif(pts_rdata_reg.y, pv_reg.y);
        ay_a = (ax == '0 && ay == '0) ? DIFF_W'(1) : ay;
        by_a = (bx == '0 && by == '0) ? DIFF_W'(1) : by;
        ca   = aclass(ax, ay);
        cb   = aclass(bx, by);
        qpx  = dif(top_reg.x, stk_rdata_reg.x);
        qpy  = dif(top_reg.y, stk_rdata_reg.y);
        rqx  = dif(cur_reg.x, top_reg.x);
        rqy  = dif(cur_reg.y, top_reg.y);
        if (ca != cb)
            goes_first = (ca < cb);
        else if (ca != 2'd1)
            goes_first = 1'b0;
        else
            goes_first = (p1_reg > p2_reg);

        ma = ax;
        mb = by_a;
        case (state_reg)
            S_SR_M2:
            begin
                ma = ay_a;
                mb = bx;
            end
            S_SC_M1:
            begin
                ma = qpx;
                mb = rqy;
            end
            S_SC_M2:
            begin
                ma = qpy;
                mb = rqx;
            end
            default:
            begin
                ma = ax;
                mb = by_a;
            end
        endcase
        prod = PROD_W'(ma) * PROD_W'(mb);
    end

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        d_next     = d_reg;
        j_next     = j_reg;
        piv_next   = piv_reg;
        st_next    = st_reg;
        pv_next    = pv_reg;
        key_next   = key_reg;
        top_next   = top_reg;
        cur_next   = cur_reg;
        p1_next    = p1_reg;
        p2_next    = p2_reg;
        pts_re     = 1'b0;
        pts_raddr  = i_reg[ADDR_W-1:0];
        pts_we     = 1'b0;
        pts_waddr  = j_reg;
        pts_wdata  = key_reg;
        stk_re     = 1'b0;
        stk_raddr  = ADDR_W'(d_reg - CNT_W'(2));
        stk_we     = 1'b0;
        stk_waddr  = d_reg[ADDR_W-1:0];
        stk_wdata  = cur_reg;
        q_pop      = 1'b0;
        res_valid  = 1'b0;
        res_data   = '0;

        case (state_reg)
            S_IDLE:
            begin
                q_pop = 1'b1;
                if (q_valid)
                begin
                    pts_we    = q_data.store;
                    pts_waddr = q_data.addr;
                    pts_wdata = q_data.pt;
                    if (q_data.last)
                    begin
                        n_next = q_data.n;
                        i_next = '0;
                        if (q_data.ovf)
                        begin
                            st_next    = ST_OVERFLOW;
                            state_next = S_STAT;
                        end
                        else if (q_data.n < CNT_W'(3))
                        begin
                            st_next    = ST_TOO_FEW;
                            state_next = S_STAT;
                        end
                        else
                            state_next = S_PV_RD;
                    end
                end
            end
            S_STAT:
            begin
                res_valid       = 1'b1;
                res_data.last   = 1'b1;
                res_data.status = st_reg;
                if (res_ready)
                    state_next = S_IDLE;
            end
            S_PV_RD:
            begin
                pts_re     = 1'b1;
                state_next = S_PV_CMP;
            end
            S_PV_CMP:
            begin
                if (i_reg == '0 || pts_rdata_reg.y < pv_reg.y)
                begin
                    pv_next  = pts_rdata_reg;
                    piv_next = i_reg[ADDR_W-1:0];
                end
                i_next = i_reg + 1'b1;
                state_next = (i_reg + 1'b1 == n_reg) ? S_SW_RD : S_PV_RD;
            end
            S_SW_RD:
            begin
                pts_re     = 1'b1;
                pts_raddr  = '0;
                state_next = S_SW_WR;
            end
            S_SW_WR:
            begin
                pts_we     = 1'b1;
                pts_waddr  = piv_reg;
                pts_wdata  = pts_rdata_reg;
                state_next = S_SW_W0;
            end
            S_SW_W0:
            begin
                pts_we     = 1'b1;
                pts_waddr  = '0;
                pts_wdata  = pv_reg;
                i_next     = CNT_W'(2);
                state_next = S_SR_KEY;
            end
            S_SR_KEY:
            begin
                if (i_reg == n_reg)
                begin
                    i_next     = '0;
                    d_next     = '0;
                    state_next = S_SC_INIT;
                end
                else
                begin
                    pts_re     = 1'b1;
                    state_next = S_SR_KEYD;
                end
            end
            S_SR_KEYD:
            begin
                key_next   = pts_rdata_reg;
                j_next     = i_reg[ADDR_W-1:0];
                state_next = S_SR_CHK;
            end
            S_SR_CHK:
            begin
                if (j_reg == ADDR_W'(1))
                begin
                    pts_we     = 1'b1;
                    i_next     = i_reg + 1'b1;
                    state_next = S_SR_KEY;
                end
                else
                begin
                    pts_re     = 1'b1;
                    pts_raddr  = j_reg - 1'b1;
                    state_next = S_SR_M1;
                end
            end
            S_SR_M1:
            begin
                p1_next    = prod;
                state_next = S_SR_M2;
            end
            S_SR_M2:
            begin
                p2_next    = prod;
                state_next = S_SR_DEC;
            end
            S_SR_DEC:
            begin
                pts_we = 1'b1;
                if (goes_first)
                begin
                    pts_wdata  = pts_rdata_reg;
                    j_next     = j_reg - 1'b1;
                    state_next = S_SR_CHK;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_SR_KEY;
                end
            end
            S_SC_INIT:
            begin
                pts_re     = 1'b1;
                state_next = S_SC_INITD;
            end
            S_SC_INITD:
            begin
                stk_we    = 1'b1;
                stk_wdata = pts_rdata_reg;
                top_next  = pts_rdata_reg;
                d_next    = d_reg + 1'b1;
                i_next    = i_reg + 1'b1;
                state_next = (i_reg == CNT_W'(2)) ? S_SC_NEXT : S_SC_INIT;
            end
            S_SC_NEXT:
            begin
                if (i_reg == n_reg)
                    state_next = S_OUT_RD;
                else
                begin
                    pts_re     = 1'b1;
                    state_next = S_SC_CUR;
                end
            end
            S_SC_CUR:
            begin
                cur_next   = pts_rdata_reg;
                state_next = S_SC_CHK;
            end
            S_SC_CHK:
            begin
                if (d_reg > CNT_W'(1))
                begin
                    stk_re     = 1'b1;
                    state_next = S_SC_M1;
                end
                else
                begin
                    stk_we     = 1'b1;
                    top_next   = cur_reg;
                    d_next     = d_reg + 1'b1;
                    i_next     = i_reg + 1'b1;
                    state_next = S_SC_NEXT;
                end
            end
            S_SC_M1:
            begin
                p1_next    = prod;
                state_next = S_SC_M2;
            end
            S_SC_M2:
            begin
                p2_next    = prod;
                state_next = S_SC_DEC;
            end
            S_SC_DEC:
            begin
                if (p1_reg > p2_reg)
                begin
                    stk_we     = 1'b1;
                    top_next   = cur_reg;
                    d_next     = d_reg + 1'b1;
                    i_next     = i_reg + 1'b1;
                    state_next = S_SC_NEXT;
                end
                else
                begin
                    top_next   = stk_rdata_reg;
                    d_next     = d_reg - 1'b1;
                    state_next = S_SC_CHK;
                end
            end
            S_OUT_RD:
            begin
                stk_re     = 1'b1;
                stk_raddr  = ADDR_W'(d_reg - 1'b1);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                res_valid       = 1'b1;
                res_data.pt     = stk_rdata_reg;
                res_data.last   = (d_reg == CNT_W'(1));
                res_data.status = ST_OK;
                if (res_ready)
                begin
                    d_next     = d_reg - 1'b1;
                    state_next = (d_reg == CNT_W'(1)) ? S_IDLE : S_OUT_RD;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            n_reg     <= '0;
            i_reg     <= '0;
            d_reg     <= '0;
            j_reg     <= '0;
            piv_reg   <= '0;
            st_reg    <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            i_reg     <= i_next;
            d_reg     <= d_next;
            j_reg     <= j_next;
            piv_reg   <= piv_next;
            st_reg    <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pv_reg  <= pv_next;
        key_reg <= key_next;
        top_reg <= top_next;
        cur_reg <= cur_next;
        p1_reg  <= p1_next;
        p2_reg  <= p2_next;
    end

    always_ff @(posedge clk)
    begin
        if (pts_we)
            pts_mem[pts_waddr] <= pts_wdata;
        if (pts_re)
            pts_rdata_reg <= pts_mem[pts_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_mem[stk_waddr] <= stk_wdata;
        if (stk_re)
            stk_rdata_reg <= stk_mem[stk_raddr];
    end

endmodule

// ----- design/convex_hull_graham_scan_top.sv -----
// Top level of the Graham scan convex hull block.
//
// Points enter on a queue-style port: push with point_x, point_y and last,
// taken when push is high and full is low; one point per cycle is taken
// while the request queue has room. last closes a set of points.
// Results leave on a queue-style port: while empty is low the oldest result
// is on hull_x, hull_y, hull_last and status, taken when pop is high.
// A set with a drop at capacity gives one result with status 2, a set of
// fewer than three points one result with status 1; otherwise hull vertices
// come out from the stack top down, hull_last on the final one.
// After the last point the back end runs pivot search, an insertion sort
// (quadratic in the set size) and the scan, then emits the vertices.
// All of it runs over one read and one write port per memory.
// Loading of the next set continues while the back end works, until the
// four-deep request queue fills.
// Reset clears the queue, counters and output valid flag; stores need no
// clearing. A stalled receiver holds the output register and the back end.
module convex_hull_graham_scan_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic signed [chgs_pkg::COORD_W-1:0]  point_x,
    input  logic signed [chgs_pkg::COORD_W-1:0]  point_y,
    input  logic                                 last,
    output logic                                 empty,
    input  logic                                 pop,
    output logic signed [chgs_pkg::COORD_W-1:0]  hull_x,
    output logic signed [chgs_pkg::COORD_W-1:0]  hull_y,
    output logic                                 hull_last,
    output logic [1:0]                           status
);
    import chgs_pkg::*;

    logic  q_push, q_full, q_valid, q_pop;
    req_t  q_wdata, q_rdata;
    logic  res_valid, res_ready;
    res_t  res_data;
    logic  out_valid_reg, out_valid_next;
    res_t  out_reg;

    chgs_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .point_x (point_x),
        .point_y (point_y),
        .last    (last),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_wdata)
    );

    chgs_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .rd    (q_pop),
        .valid (q_valid),
        .rdata (q_rdata)
    );

    chgs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_data  (res_data),
        .res_ready (res_ready)
    );

    assign full      = q_full;
    assign empty     = !out_valid_reg;
    assign res_ready = !out_valid_reg || pop;
    assign hull_x    = out_reg.pt.x;
    assign hull_y    = out_reg.pt.y;
    assign hull_last = out_reg.last;
    assign status    = out_reg.status;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
            out_reg <= res_data;
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("request pushed into full queue");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("back end dropped a stalled result");

    a_stat_last: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && status != ST_OK |-> hull_last && hull_x == '0 && hull_y == '0)
        else $error("status result not final or not zero");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty)
        else $error("output register lost a result");

endmodule

// ----- tb/chgs_checker.sv -----
// Checker for the convex hull block: predicts hull results from accepted points and compares.
module chgs_checker
    import chgs_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic                       full,
    input  logic signed [COORD_W-1:0]  point_x,
    input  logic signed [COORD_W-1:0]  point_y,
    input  logic                       last,
    input  logic                       empty,
    input  logic                       pop,
    input  logic signed [COORD_W-1:0]  hull_x,
    input  logic signed [COORD_W-1:0]  hull_y,
    input  logic                       hull_last,
    input  logic [1:0]                 status,
    output int                         pending,
    output int                         fail_count,
    output int                         sets_done,
    output int                         vertices_seen,
    output int                         short_sets,
    output int                         dropped_sets
);
    timeunit 1ns;
    timeprecision 1ps;

    longint set_x [MAX_POINTS];
    longint set_y [MAX_POINTS];
    int     set_len;
    bit     set_ovf;
    res_t   hull_q [$];

    task automatic report(input string what);
        $display("hull check: %s at %0t", what, $realtime);
        fail_count++;
    endtask

    function automatic int angle_cls(longint dx, longint dy);
        if (dy == 0 && dx > 0) return 0;
        if (dy == 0 && dx < 0) return 2;
        return 1;
    endfunction

    function automatic bit steeper(longint ax, longint ay, longint bx, longint by);
        int ca;
        int cb;
        ca = angle_cls(ax, ay);
        cb = angle_cls(bx, by);
        if (ca != cb) return ca < cb;
        if (ca != 1) return 0;
        if (ax == 0 && ay == 0) ay = 1;
        if (bx == 0 && by == 0) by = 1;
        return (ax * by - ay * bx) > 0;
    endfunction

    function automatic bit turns_left(int p, int q, int r);
        return ((set_x[q] - set_x[p]) * (set_y[r] - set_y[q]) -
                (set_y[q] - set_y[p]) * (set_x[r] - set_x[q])) > 0;
    endfunction

    function automatic void add_result(longint x, longint y, bit l, logic [1:0] st);
        res_t r;
        r.pt.x   = x[COORD_W-1:0];
        r.pt.y   = y[COORD_W-1:0];
        r.last   = l;
        r.status = st;
        hull_q = {hull_q, r};
    endfunction

    function automatic void build_hull();
        int     piv;
        int     j;
        int     depth;
        int     stk [MAX_POINTS];
        longint kx;
        longint ky;
        piv = 0;
        for (int i = 1; i < set_len; i++)
            if (set_y[i] < set_y[piv]) piv = i;
        kx = set_x[0];
        ky = set_y[0];
        set_x[0] = set_x[piv];
        set_y[0] = set_y[piv];
        set_x[piv] = kx;
        set_y[piv] = ky;
        for (int i = 2; i < set_len; i++) begin
            kx = set_x[i];
            ky = set_y[i];
            j = i;
            while (j > 1 && steeper(kx - set_x[0], ky - set_y[0],
                                    set_x[j-1] - set_x[0], set_y[j-1] - set_y[0])) begin
                set_x[j] = set_x[j-1];
                set_y[j] = set_y[j-1];
                j--;
            end
            set_x[j] = kx;
            set_y[j] = ky;
        end
        stk[0] = 0;
        stk[1] = 1;
        stk[2] = 2;
        depth = 3;
        for (int i = 3; i < set_len; i++) begin
            while (depth > 1 && !turns_left(stk[depth-2], stk[depth-1], i))
                depth--;
            stk[depth] = i;
            depth++;
        end
        for (int k = 0; k < depth; k++)
            add_result(set_x[stk[depth-1-k]], set_y[stk[depth-1-k]], k == depth - 1, ST_OK);
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            set_len = 0;
            set_ovf = 0;
        end else begin
            if (push && !full) begin
                if (set_len < MAX_POINTS) begin
                    set_x[set_len] = point_x;
                    set_y[set_len] = point_y;
                    set_len = set_len + 1;
                end else begin
                    set_ovf = 1;
                end
                if (last) begin
                    sets_done++;
                    if (set_ovf) begin
                        add_result(0, 0, 1, ST_OVERFLOW);
                        dropped_sets++;
                    end else if (set_len < 3) begin
                        add_result(0, 0, 1, ST_TOO_FEW);
                        short_sets++;
                    end else begin
                        build_hull();
                    end
                    set_len = 0;
                    set_ovf = 0;
                end
            end
            if (pop && !empty) begin
                if (hull_q.size() == 0) begin
                    report("result with nothing expected");
                end else begin
                    res_t e;
                    e = hull_q.pop_front();
                    vertices_seen++;
                    if (hull_x !== e.pt.x)
                        report($sformatf("hull_x %0d, want %0d", hull_x, $signed(e.pt.x)));
                    if (hull_y !== e.pt.y)
                        report($sformatf("hull_y %0d, want %0d", hull_y, $signed(e.pt.y)));
                    if (hull_last !== e.last)
                        report($sformatf("hull_last %0b, want %0b", hull_last, e.last));
                    if (status !== e.status)
                        report($sformatf("status %0d, want %0d", status, e.status));
                end
            end
            pending = hull_q.size();
        end
    end

    initial begin
        pending       = 0;
        fail_count    = 0;
        sets_done     = 0;
        vertices_seen = 0;
        short_sets    = 0;
        dropped_sets  = 0;
    end
endmodule

// ----- tb/convex_hull_graham_scan_top_tb.sv -----
// Testbench top for the convex hull block: point stimulus, result draining and verdict.
module convex_hull_graham_scan_top_tb;
    import chgs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                      clk;
    logic                      rst_n;
    logic                      push;
    logic                      full;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      last;
    logic                      empty;
    logic                      pop;
    logic signed [COORD_W-1:0] hull_x;
    logic signed [COORD_W-1:0] hull_y;
    logic                      hull_last;
    logic [1:0]                status;

    int pending;
    int fail_count;
    int sets_done;
    int vertices_seen;
    int short_sets;
    int dropped_sets;
    int points_sent;
    bit hold_req;
    bit quiet_push;

    convex_hull_graham_scan_top uut (.*);

    chgs_checker chk (.*);

    initial begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial begin
        #20ms;
        $display("convex_hull_graham_scan_top: mismatch");
        $finish;
    end

    task automatic send_point(input int x, input int y, input bit l);
        push    <= 1;
        point_x <= x[COORD_W-1:0];
        point_y <= y[COORD_W-1:0];
        last    <= l;
        do @(posedge clk); while (full);
        points_sent++;
        if (!quiet_push && $urandom_range(99) < 28) begin
            push <= 0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
    endtask

    function automatic int pick_coord(int mode);
        case (mode)
            0: return $signed(16'($urandom));
            1: return $urandom_range(8) - 4;
            default: return $urandom_range(1) ? 32767 - $urandom_range(3)
                                              : -32768 + $urandom_range(3);
        endcase
    endfunction

    task automatic send_set(input int len);
        int mode;
        mode = $urandom_range(9) < 5 ? 0 : ($urandom_range(2) == 0 ? 2 : 1);
        for (int i = 0; i < len; i++)
            send_point(pick_coord(mode), pick_coord(mode), i == len - 1);
    endtask

    // receiver
    initial begin
        int cyc;
        pop = 0;
        cyc = 0;
        @(posedge rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 0;
                pop <= 0;
                repeat (600) @(posedge clk);
            end
            pop <= (cyc > 3000 && cyc < 5000) ? 1'b1 : ($urandom_range(99) >= 28);
            @(posedge clk);
            cyc++;
        end
    end

    initial begin
        int len;
        push        = 0;
        point_x     = 0;
        point_y     = 0;
        last        = 0;
        hold_req    = 0;
        quiet_push  = 0;
        points_sent = 0;
        rst_n       = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_point(-32768, -32768, 0);
        send_point(32767, 32767, 0);
        send_point(-32768, 32767, 1);
        send_point(0, 0, 0);
        send_point(1, 1, 0);
        send_point(2, 2, 0);
        send_point(0, 0, 0);
        send_point(2, 0, 0);
        send_point(-2, 0, 1);
        send_point(7, 7, 1);
        send_point(-1, 5, 0);
        send_point(3, -3, 1);
        send_point(0, 10, 0);
        send_point(10, 0, 0);
        send_point(10, 10, 0);
        send_point(0, 0, 0);
        send_point(5, 5, 0);
        send_point(32767, -32768, 1);

        while (points_sent < 480) begin
            if (points_sent > 120 && points_sent < 140)
                hold_req = 1;
            quiet_push = points_sent > 250 && points_sent < 350;
            if (points_sent > 300 && points_sent < 320) begin
                push <= 0;
                do @(posedge clk); while (pending != 0);
            end
            case ($urandom_range(19))
                0: len = $urandom_range(1, 2);
                1: len = 64 + $urandom_range(2);
                default: len = $urandom_range(3, 12);
            endcase
            send_set(len);
        end
        push <= 0;
        do @(posedge clk); while (pending != 0);
        repeat (200) @(posedge clk);

        $display("%0d points in %0d sets, %0d results checked", points_sent, sets_done,
                 vertices_seen);
        $display("%0d sets below three points, %0d sets over capacity", short_sets,
                 dropped_sets);
        if (fail_count == 0 && pending == 0)
            $display("convex_hull_graham_scan_top: match");
        else
            $display("convex_hull_graham_scan_top: mismatch");
        $finish;
    end
endmodule

// ----- files.f -----
design/chgs_pkg.sv
design/chgs_fifo.sv
design/chgs_front.sv
design/chgs_back.sv
design/convex_hull_graham_scan_top.sv
tb/chgs_checker.sv
tb/convex_hull_graham_scan_top_tb.sv
